### design/imgc_pkg.sv
// Package for the 3x3 clamped image convolution block.
// Holds shared widths, codes, control structs and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package imgc_pkg;

   localparam int COORD_W    = 14;
   localparam int POS_W      = 7;
   localparam int PIXEL_W    = 8;
   localparam int WEIGHT_W   = 16;
   localparam int FRAC_W     = 12;
   localparam int COEF_TAPS  = 3;
   localparam int TAP_IDX_W  = 2;
   localparam int PROD_W     = PIXEL_W + 1 + WEIGHT_W;
   localparam int ACC_W      = 28;
   localparam int CSR_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int OFFSET_W   = 2;
   localparam int REQ_DATA_W = 24;

   localparam int DEF_FRAME_COLS  = 128;
   localparam int DEF_FRAME_ROWS  = 128;
   localparam int DEF_KERNEL_SIZE = 3;

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_FILTER = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_COEF_0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_COL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_ROW = 3'd4;

   localparam logic [CSR_DATA_W-1:0] COEF_0_RESET = 48'h0;
   localparam logic [CSR_DATA_W-1:0] COEF_1_RESET = 48'h0000_1000_0000;
   localparam logic [CSR_DATA_W-1:0] COEF_2_RESET = 48'h0;
   localparam logic [OFFSET_W-1:0]   OFFSET_RESET = 2'd1;

   typedef logic [COEF_TAPS-1:0][COEF_TAPS-1:0][WEIGHT_W-1:0] coef_bank_type;

   typedef struct packed {
      logic                       clear;
      logic                       centre;
      logic                       tap;
      logic                       use_centre;
      logic signed [WEIGHT_W-1:0] weight;
   } tap_ctl_type;

   typedef struct packed {
      logic load;
      logic zero;
   } rsp_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CENTRE,
      ST_TAPS,
      ST_DRAIN,
      ST_FINISH
   } ctrl_state_type;

endpackage

`default_nettype wire

### design/imgc_frame_mem.sv
// Frame memory: one write port and one read port with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module imgc_frame_mem #(
   parameter int DEPTH  = 16384,
   parameter int DATA_W = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_W-1:0]        wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/imgc_mac.sv
// Multiply-accumulate datapath: weights each returned tap, sums in Q.12 and clamps.
// Depends on imgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imgc_mac
   import imgc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tap_ctl_type        tap_ctl,
   input  wire logic [PIXEL_W-1:0] rd_data,
   output logic                    busy,
   output logic      [PIXEL_W-1:0] filtered
);

   logic        [PIXEL_W-1:0] centre_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic                      prod_vld_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic        [PIXEL_W-1:0] pix;
   logic        [ACC_W-FRAC_W-1:0] whole;

   always_comb begin
      pix     = tap_ctl.use_centre ? centre_ff : rd_data;
      prod_in = PROD_W'(signed'({1'b0, pix}) * tap_ctl.weight);
   end

   always_ff @(posedge clock) begin
      if (tap_ctl.centre) begin
         centre_ff <= rd_data;
      end
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
         acc_ff      <= '0;
      end else begin
         prod_vld_ff <= tap_ctl.tap;
         if (tap_ctl.clear) begin
            acc_ff <= '0;
         end else if (prod_vld_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   always_comb begin
      whole = acc_ff[ACC_W-1:FRAC_W];
      if (acc_ff[ACC_W-1]) begin
         filtered = '0;
      end else if (whole > (ACC_W-FRAC_W)'(255)) begin
         filtered = '1;
      end else begin
         filtered = whole[PIXEL_W-1:0];
      end
   end

   assign busy = prod_vld_ff;

endmodule

`default_nettype wire

### design/imgc_filter_ctrl.sv
// Sequencer: stores pixels, walks the kernel taps through the frame memory read
// port and hands tap controls to the datapath. Depends on imgc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module imgc_filter_ctrl
   import imgc_pkg::*;
#(
   parameter int FRAME_COLS  = DEF_FRAME_COLS,
   parameter int FRAME_ROWS  = DEF_FRAME_ROWS,
   parameter int KERNEL_SIZE = DEF_KERNEL_SIZE
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire logic                                       req_valid,
   output logic                                            req_ready,
   input  wire logic                                       req_action,
   input  wire logic [POS_W-1:0]                           req_col,
   input  wire logic [POS_W-1:0]                           req_row,
   input  wire logic [PIXEL_W-1:0]                         req_pixel,
   input  wire coef_bank_type                              coef,
   input  wire logic [OFFSET_W-1:0]                        offset_col,
   input  wire logic [OFFSET_W-1:0]                        offset_row,
   input  wire logic                                       mac_busy,
   input  wire logic                                       rsp_free,
   output rsp_ctl_type                                     rsp_ctl,
   output tap_ctl_type                                     tap_ctl,
   output logic                                            wr_en,
   output logic [$clog2(FRAME_COLS*FRAME_ROWS)-1:0]        wr_addr,
   output logic [PIXEL_W-1:0]                              wr_data,
   output logic                                            rd_en,
   output logic [$clog2(FRAME_COLS*FRAME_ROWS)-1:0]        rd_addr
);

   localparam int AddrW = $clog2(FRAME_COLS * FRAME_ROWS);
   localparam int WideW = 2 * COORD_W;

   function automatic logic [AddrW-1:0] addr_of(logic [COORD_W-1:0] c,
                                                logic [COORD_W-1:0] r);
      logic [WideW-1:0] w;
      w = WideW'(r) * WideW'(FRAME_COLS) + WideW'(c);
      return w[AddrW-1:0];
   endfunction

   ctrl_state_type           state_ff, state_in;
   logic [POS_W-1:0]         col_ff, col_in;
   logic [POS_W-1:0]         row_ff, row_in;
   logic [TAP_IDX_W-1:0]     i_ff, i_in;
   logic [TAP_IDX_W-1:0]     j_ff, j_in;
   logic                     zero_ff, zero_in;
   tap_ctl_type              tap_ff, tap_in;
   logic                     accept;
   logic                     in_frame;
   logic signed [COORD_W-1:0] tc;
   logic signed [COORD_W-1:0] tr;
   logic                     tap_in_frame;
   logic                     last_tap;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         zero_ff  <= 1'b0;
         tap_ff   <= '0;
      end else begin
         state_ff <= state_in;
         zero_ff  <= zero_in;
         tap_ff   <= tap_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff <= col_in;
      row_ff <= row_in;
      i_ff   <= i_in;
      j_ff   <= j_in;
   end

   always_comb begin
      in_frame = (COORD_W'(req_col) < COORD_W'(FRAME_COLS))
              && (COORD_W'(req_row) < COORD_W'(FRAME_ROWS));
      tc = signed'(COORD_W'(col_ff)) - signed'(COORD_W'(offset_col))
         + signed'(COORD_W'(i_ff));
      tr = signed'(COORD_W'(row_ff)) - signed'(COORD_W'(offset_row))
         + signed'(COORD_W'(j_ff));
      tap_in_frame = (tc >= 0) && (tc < signed'(COORD_W'(FRAME_COLS)))
                  && (tr >= 0) && (tr < signed'(COORD_W'(FRAME_ROWS)));
      last_tap = (i_ff == TAP_IDX_W'(KERNEL_SIZE - 1))
              && (j_ff == TAP_IDX_W'(KERNEL_SIZE - 1));
   end

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      zero_in   = zero_ff;
      tap_in    = '0;
      req_ready = 1'b0;
      accept    = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = addr_of(COORD_W'(req_col), COORD_W'(req_row));
      wr_data   = req_pixel;
      rd_en     = 1'b0;
      rd_addr   = addr_of(COORD_W'(col_ff), COORD_W'(row_ff));
      rsp_ctl   = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            accept    = req_valid;
            if (accept) begin
               col_in = req_col;
               row_in = req_row;
               if (req_action == ACT_WRITE) begin
                  wr_en = in_frame;
               end else if (in_frame) begin
                  state_in = ST_CENTRE;
               end else begin
                  zero_in  = 1'b1;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_CENTRE: begin
            rd_en        = 1'b1;
            tap_in.clear = 1'b1;
            tap_in.centre = 1'b1;
            zero_in      = 1'b0;
            i_in         = '0;
            j_in         = '0;
            state_in     = ST_TAPS;
         end
         ST_TAPS: begin
            rd_en             = tap_in_frame;
            rd_addr           = addr_of(tc, tr);
            tap_in.tap        = 1'b1;
            tap_in.use_centre = !tap_in_frame;
            tap_in.weight     = signed'(coef[i_ff][j_ff]);
            if (last_tap) begin
               state_in = ST_DRAIN;
            end else if (j_ff == TAP_IDX_W'(KERNEL_SIZE - 1)) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!tap_ff.tap && !mac_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_ctl.load = 1'b1;
               rsp_ctl.zero = zero_ff;
               zero_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign tap_ctl = tap_ff;

endmodule

`default_nettype wire

### design/image_convolution_3x3_clamped.sv
// Top level of the 3x3 clamped image convolution over a stored 8-bit frame.
// Depends on imgc_pkg, imgc_frame_mem, imgc_filter_ctrl and imgc_mac.
//
//   Group   Direction   Contents
//   req_    in          pixel writes and filter requests
//   rsp_    out         filtered pixel, one word per filter request
//   csr_    in          coefficient and offset register writes
//
// A pixel write inside the frame is stored from the idle state. For a filter request
// inside the frame the frame memory read port delivers the centre pixel and then one
// tap per cycle, followed by the multiply and accumulate stages. A request outside
// the frame skips the reads and returns zero. Each result waits for a free output register.
// Reset is synchronous and leaves the frame memory contents undefined.
// A result waits in the output register while the next word is taken in.
`timescale 1ns / 1ps
`default_nettype none

module image_convolution_3x3_clamped
   import imgc_pkg::*;
#(
   parameter int FRAME_COLS  = DEF_FRAME_COLS,
   parameter int FRAME_ROWS  = DEF_FRAME_ROWS,
   parameter int KERNEL_SIZE = DEF_KERNEL_SIZE
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // col, row, pixel_in, zero fill
   input  wire logic                  req_tuser,   // action
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [PIXEL_W-1:0]    rsp_tdata,   // filtered
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int Depth = FRAME_COLS * FRAME_ROWS;
   localparam int AddrW = $clog2(Depth);

   coef_bank_type       coef_ff;
   logic [OFFSET_W-1:0] offset_col_ff;
   logic [OFFSET_W-1:0] offset_row_ff;
   logic                rsp_valid_ff;
   logic [PIXEL_W-1:0]  rsp_data_ff;

   rsp_ctl_type         rsp_ctl;
   tap_ctl_type         tap_ctl;
   logic                mac_busy;
   logic [PIXEL_W-1:0]  filtered;
   logic                wr_en;
   logic [AddrW-1:0]    wr_addr;
   logic [PIXEL_W-1:0]  wr_data;
   logic                rd_en;
   logic [AddrW-1:0]    rd_addr;
   logic [PIXEL_W-1:0]  rd_data;
   logic                rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[0]    <= COEF_0_RESET;
         coef_ff[1]    <= COEF_1_RESET;
         coef_ff[2]    <= COEF_2_RESET;
         offset_col_ff <= OFFSET_RESET;
         offset_row_ff <= OFFSET_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_COEF_0:     coef_ff[0]    <= csr_wdata;
            CSR_COEF_1:     coef_ff[1]    <= csr_wdata;
            CSR_COEF_2:     coef_ff[2]    <= csr_wdata;
            CSR_OFFSET_COL: offset_col_ff <= csr_wdata[OFFSET_W-1:0];
            CSR_OFFSET_ROW: offset_row_ff <= csr_wdata[OFFSET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_ctl.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_ctl.load) begin
         rsp_data_ff <= rsp_ctl.zero ? '0 : filtered;
      end
   end

   imgc_filter_ctrl #(
      .FRAME_COLS  (FRAME_COLS),
      .FRAME_ROWS  (FRAME_ROWS),
      .KERNEL_SIZE (KERNEL_SIZE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_action (req_tuser),
      .req_col    (req_tdata[POS_W-1:0]),
      .req_row    (req_tdata[2*POS_W-1:POS_W]),
      .req_pixel  (req_tdata[2*POS_W+PIXEL_W-1:2*POS_W]),
      .coef       (coef_ff),
      .offset_col (offset_col_ff),
      .offset_row (offset_row_ff),
      .mac_busy   (mac_busy),
      .rsp_free   (rsp_free),
      .rsp_ctl    (rsp_ctl),
      .tap_ctl    (tap_ctl),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr)
   );

   imgc_frame_mem #(
      .DEPTH  (Depth),
      .DATA_W (PIXEL_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   imgc_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .tap_ctl  (tap_ctl),
      .rd_data  (rd_data),
      .busy     (mac_busy),
      .filtered (filtered)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for image_convolution_3x3_clamped.
// Drives pixel writes, filter requests and register writes, and predicts each filtered word.
// Depends on imgc_pkg and the design sources.
`timescale 1ns / 1ps

module tb;
   import imgc_pkg::*;

   localparam int FRAME_WORDS   = DEF_FRAME_COLS * DEF_FRAME_ROWS;
   localparam int SETTLE_CYCLES = 24;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = ACT_WRITE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [PIXEL_W-1:0]    rsp_tdata;
   logic                  csr_wr_en  = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = CSR_COEF_0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   logic [PIXEL_W-1:0]    frame_copy [FRAME_WORDS];
   bit                    pixel_written [FRAME_WORDS];
   logic [CSR_DATA_W-1:0] coef_copy [COEF_TAPS];
   logic [OFFSET_W-1:0]   origin_col;
   logic [OFFSET_W-1:0]   origin_row;
   logic [PIXEL_W-1:0]    pending_filtered [$];
   logic [PIXEL_W-1:0]    expected_word;

   bit tx_idle_en  = 1'b1;
   bit rx_stall_en = 1'b1;
   int stall_left  = 0;
   int items_sent  = 0;
   int write_count = 0;
   int filter_count = 0;
   int reg_writes  = 0;
   int checked_count = 0;
   int fail_count  = 0;

   image_convolution_3x3_clamped dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [PIXEL_W-1:0] convolve_at(input int col, input int row);
      logic [PIXEL_W-1:0]         centre;
      logic [PIXEL_W-1:0]         tap_value;
      logic signed [WEIGHT_W-1:0] weight;
      longint                     acc;
      int                         tc;
      int                         tr;
      centre = frame_copy[row * DEF_FRAME_COLS + col];
      acc = 0;
      for (int i = 0; i < DEF_KERNEL_SIZE; i++) begin
         for (int j = 0; j < DEF_KERNEL_SIZE; j++) begin
            tc = col - int'(origin_col) + i;
            tr = row - int'(origin_row) + j;
            if (tc >= 0 && tc < DEF_FRAME_COLS && tr >= 0 && tr < DEF_FRAME_ROWS) begin
               tap_value = frame_copy[tr * DEF_FRAME_COLS + tc];
            end else begin
               tap_value = centre;
            end
            weight = coef_copy[i][WEIGHT_W*j +: WEIGHT_W];
            acc += longint'(tap_value) * longint'(weight);
         end
      end
      if (acc < 0) begin
         return '0;
      end else if ((acc >>> FRAC_W) > 255) begin
         return 8'hFF;
      end else begin
         return acc[FRAC_W +: PIXEL_W];
      end
   endfunction

   function automatic logic [CSR_DATA_W-1:0] mild_coef_group();
      logic [CSR_DATA_W-1:0] group;
      for (int j = 0; j < COEF_TAPS; j++) begin
         group[WEIGHT_W*j +: WEIGHT_W] = WEIGHT_W'($urandom_range(0, 1536)) - 16'd512;
      end
      return group;
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (rx_stall_en && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_filtered.size() == 0) begin
            $display("%t unexpected filtered word: expected none, actual %0d", $time, rsp_tdata);
            fail_count++;
         end else begin
            expected_word = pending_filtered.pop_front();
            checked_count++;
            if (rsp_tdata !== expected_word) begin
               $display("%t filtered mismatch: expected %0d, actual %0d",
                        $time, expected_word, rsp_tdata);
               fail_count++;
            end
         end
      end
   end

   task automatic send_word(input logic action, input int col, input int row,
                            input logic [PIXEL_W-1:0] pixel);
      if (tx_idle_en && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {2'b00, pixel, POS_W'(row), POS_W'(col)};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (action == ACT_WRITE) begin
         frame_copy[row * DEF_FRAME_COLS + col] = pixel;
         pixel_written[row * DEF_FRAME_COLS + col] = 1'b1;
         write_count++;
      end else begin
         pending_filtered.push_back(convolve_at(col, row));
         filter_count++;
      end
   endtask

   task automatic fill_taps(input int col, input int row);
      int tc;
      int tr;
      if (!pixel_written[row * DEF_FRAME_COLS + col]) begin
         send_word(ACT_WRITE, col, row, PIXEL_W'($urandom_range(0, 255)));
      end
      for (int i = 0; i < DEF_KERNEL_SIZE; i++) begin
         for (int j = 0; j < DEF_KERNEL_SIZE; j++) begin
            tc = col - int'(origin_col) + i;
            tr = row - int'(origin_row) + j;
            if (tc >= 0 && tc < DEF_FRAME_COLS && tr >= 0 && tr < DEF_FRAME_ROWS &&
                !pixel_written[tr * DEF_FRAME_COLS + tc]) begin
               send_word(ACT_WRITE, tc, tr, PIXEL_W'($urandom_range(0, 255)));
            end
         end
      end
   endtask

   task automatic filter_at(input int col, input int row);
      fill_taps(col, row);
      send_word(ACT_FILTER, col, row, PIXEL_W'($urandom_range(0, 255)));
   endtask

   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_filtered.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      reg_writes++;
      case (index)
         CSR_COEF_0:     coef_copy[0] = value;
         CSR_COEF_1:     coef_copy[1] = value;
         CSR_COEF_2:     coef_copy[2] = value;
         CSR_OFFSET_COL: origin_col = value[OFFSET_W-1:0];
         CSR_OFFSET_ROW: origin_row = value[OFFSET_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_kernel(input logic [CSR_DATA_W-1:0] c0, input logic [CSR_DATA_W-1:0] c1,
                             input logic [CSR_DATA_W-1:0] c2, input logic [OFFSET_W-1:0] oc,
                             input logic [OFFSET_W-1:0] orow);
      settle_block();
      write_reg(CSR_COEF_0, c0);
      write_reg(CSR_COEF_1, c1);
      write_reg(CSR_COEF_2, c2);
      write_reg(CSR_OFFSET_COL, CSR_DATA_W'(oc));
      write_reg(CSR_OFFSET_ROW, CSR_DATA_W'(orow));
   endtask

   task automatic pick_position(output int col, output int row);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 2) begin
         col = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(124, 127);
         row = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(124, 127);
      end else if (sel < 7) begin
         col = $urandom_range(60, 67);
         row = $urandom_range(60, 67);
      end else begin
         col = $urandom_range(0, DEF_FRAME_COLS - 1);
         row = $urandom_range(0, DEF_FRAME_ROWS - 1);
      end
   endtask

   task automatic random_traffic(input int count);
      int stop_at;
      int col;
      int row;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick_position(col, row);
         if ($urandom_range(0, 99) < 25) begin
            send_word(ACT_WRITE, col, row, PIXEL_W'($urandom_range(0, 255)));
         end else begin
            filter_at(col, row);
         end
      end
   endtask

   // The reset kernel is the identity, so each corner must return its own pixel.
   task automatic test_reset_kernel_corners();
      send_word(ACT_WRITE, 0, 0, 8'hFF);
      filter_at(0, 0);
      send_word(ACT_WRITE, DEF_FRAME_COLS - 1, DEF_FRAME_ROWS - 1, 8'h00);
      filter_at(DEF_FRAME_COLS - 1, DEF_FRAME_ROWS - 1);
      send_word(ACT_WRITE, 0, DEF_FRAME_ROWS - 1, 8'hAA);
      filter_at(0, DEF_FRAME_ROWS - 1);
      send_word(ACT_WRITE, DEF_FRAME_COLS - 1, 0, 8'h55);
      filter_at(DEF_FRAME_COLS - 1, 0);
   endtask

   // With an offset of three every tap at the origin corner falls outside the frame.
   task automatic test_clamp_extremes();
      set_kernel(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 2'd3, 2'd3);
      filter_at(0, 0);
      set_kernel(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 2'd3, 2'd3);
      filter_at(0, 0);
      set_kernel('1, '1, '1, 2'd0, 2'd0);
      filter_at(DEF_FRAME_COLS - 1, DEF_FRAME_ROWS - 1);
      filter_at(0, 0);
      set_kernel('0, '0, '0, 2'd2, 2'd0);
      filter_at(0, 0);
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 6; phase++) begin
         settle_block();
         if (phase == 5) begin
            tx_idle_en  = 1'b0;
            rx_stall_en = 1'b0;
         end
         if (phase % 3 == 1) begin
            set_kernel(CSR_DATA_W'({$urandom, $urandom}), CSR_DATA_W'({$urandom, $urandom}),
                       CSR_DATA_W'({$urandom, $urandom}), OFFSET_W'($urandom_range(0, 3)),
                       OFFSET_W'($urandom_range(0, 3)));
         end else begin
            set_kernel(mild_coef_group(), mild_coef_group(), mild_coef_group(),
                       OFFSET_W'($urandom_range(0, 3)), OFFSET_W'($urandom_range(0, 3)));
         end
         random_traffic(142);
      end
   endtask

   initial begin
      coef_copy[0] = COEF_0_RESET;
      coef_copy[1] = COEF_1_RESET;
      coef_copy[2] = COEF_2_RESET;
      origin_col   = OFFSET_RESET;
      origin_row   = OFFSET_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_kernel_corners();
      test_clamp_extremes();
      test_random_phases();
      settle_block();
      $display("Sent %0d pixel writes and %0d filter requests across %0d register writes.",
               write_count, filter_count, reg_writes);
      $display("Compared %0d filtered words with the predicted values.", checked_count);
      if (fail_count == 0) begin
         $display("image_convolution_3x3_clamped: match");
      end else begin
         $display("image_convolution_3x3_clamped: mismatch");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d filtered words outstanding.", pending_filtered.size());
      $display("image_convolution_3x3_clamped: mismatch");
      $finish;
   end

endmodule
